/* hdl/tmcm_pkg.sv */
// ----------------------------------------------------------------------------
// tmcm_pkg: shared types and constants
// Register indexes, flag bit positions, reset values and state enums used
// across the touch calibration datapath.
// ----------------------------------------------------------------------------
package tmcm_pkg;

  localparam int SCR_BITS = 10;
  localparam int CFG_DATA_BITS = 32;
  localparam int CFG_ADDR_BITS = 5;
  localparam int REG_IDX_BITS = 3;

  localparam logic [REG_IDX_BITS-1:0] REG_RAW_MIN_X   = 3'd0;
  localparam logic [REG_IDX_BITS-1:0] REG_RAW_MAX_X   = 3'd1;
  localparam logic [REG_IDX_BITS-1:0] REG_RAW_MIN_Y   = 3'd2;
  localparam logic [REG_IDX_BITS-1:0] REG_RAW_MAX_Y   = 3'd3;
  localparam logic [REG_IDX_BITS-1:0] REG_PRESS_THR   = 3'd4;
  localparam logic [REG_IDX_BITS-1:0] REG_ORIENT      = 3'd5;
  localparam logic [REG_IDX_BITS-1:0] REG_SCR_MAX_X   = 3'd6;
  localparam logic [REG_IDX_BITS-1:0] REG_SCR_MAX_Y   = 3'd7;

  localparam int RST_RAW_MIN = 550;
  localparam int RST_RAW_MAX = 3650;
  localparam int RST_PRESS_THR = 850;
  localparam logic [3:0] RST_ORIENT = 4'd13;
  localparam logic [SCR_BITS-1:0] RST_SCR_MAX_X = 10'd319;
  localparam logic [SCR_BITS-1:0] RST_SCR_MAX_Y = 10'd239;

  localparam int FLG_SWAP = 0;
  localparam int FLG_INV_X = 1;
  localparam int FLG_INV_Y = 2;
  localparam int FLG_LOW_Z = 3;

  typedef enum logic [2:0] {
    TS_IDLE,
    TS_CHECK,
    TS_MIRROR,
    TS_CLAMP,
    TS_START,
    TS_WAIT,
    TS_OUT
  } top_state_t;

  typedef enum logic [1:0] {
    MD_IDLE,
    MD_MUL,
    MD_DIV,
    MD_DONE
  } md_state_t;

endpackage

/* hdl/tmcm_regs.sv */
// ----------------------------------------------------------------------------
// tmcm_regs: configuration register file
// APB-style write/read access to the calibration, threshold, orientation and
// screen size registers.
// ----------------------------------------------------------------------------
module tmcm_regs #(
  parameter int RAW_BITS = 12
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [tmcm_pkg::CFG_ADDR_BITS-1:0]    paddr,
  input  logic [tmcm_pkg::CFG_DATA_BITS-1:0]    pwdata,
  output logic [tmcm_pkg::CFG_DATA_BITS-1:0]    prdata,
  output logic [RAW_BITS-1:0]                   raw_min_x,
  output logic [RAW_BITS-1:0]                   raw_max_x,
  output logic [RAW_BITS-1:0]                   raw_min_y,
  output logic [RAW_BITS-1:0]                   raw_max_y,
  output logic [RAW_BITS-1:0]                   press_thr,
  output logic [3:0]                            orient,
  output logic [tmcm_pkg::SCR_BITS-1:0]         scr_max_x,
  output logic [tmcm_pkg::SCR_BITS-1:0]         scr_max_y
);

  localparam int DW = tmcm_pkg::CFG_DATA_BITS;

  logic [RAW_BITS-1:0] raw_min_x_r, raw_max_x_r, raw_min_y_r, raw_max_y_r, press_thr_r;
  logic [3:0] orient_r;
  logic [tmcm_pkg::SCR_BITS-1:0] scr_max_x_r, scr_max_y_r;
  logic [tmcm_pkg::REG_IDX_BITS-1:0] idx;
  logic wr_en;

  assign idx = paddr[tmcm_pkg::CFG_ADDR_BITS-1:2];
  assign wr_en = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raw_min_x_r <= RAW_BITS'(tmcm_pkg::RST_RAW_MIN);
      raw_max_x_r <= RAW_BITS'(tmcm_pkg::RST_RAW_MAX);
      raw_min_y_r <= RAW_BITS'(tmcm_pkg::RST_RAW_MIN);
      raw_max_y_r <= RAW_BITS'(tmcm_pkg::RST_RAW_MAX);
      press_thr_r <= RAW_BITS'(tmcm_pkg::RST_PRESS_THR);
      orient_r    <= tmcm_pkg::RST_ORIENT;
      scr_max_x_r <= tmcm_pkg::RST_SCR_MAX_X;
      scr_max_y_r <= tmcm_pkg::RST_SCR_MAX_Y;
    end else if (wr_en) begin
      case (idx)
        tmcm_pkg::REG_RAW_MIN_X: raw_min_x_r <= pwdata[RAW_BITS-1:0];
        tmcm_pkg::REG_RAW_MAX_X: raw_max_x_r <= pwdata[RAW_BITS-1:0];
        tmcm_pkg::REG_RAW_MIN_Y: raw_min_y_r <= pwdata[RAW_BITS-1:0];
        tmcm_pkg::REG_RAW_MAX_Y: raw_max_y_r <= pwdata[RAW_BITS-1:0];
        tmcm_pkg::REG_PRESS_THR: press_thr_r <= pwdata[RAW_BITS-1:0];
        tmcm_pkg::REG_ORIENT:    orient_r    <= pwdata[3:0];
        tmcm_pkg::REG_SCR_MAX_X: scr_max_x_r <= pwdata[tmcm_pkg::SCR_BITS-1:0];
        tmcm_pkg::REG_SCR_MAX_Y: scr_max_y_r <= pwdata[tmcm_pkg::SCR_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      tmcm_pkg::REG_RAW_MIN_X: prdata = DW'(raw_min_x_r);
      tmcm_pkg::REG_RAW_MAX_X: prdata = DW'(raw_max_x_r);
      tmcm_pkg::REG_RAW_MIN_Y: prdata = DW'(raw_min_y_r);
      tmcm_pkg::REG_RAW_MAX_Y: prdata = DW'(raw_max_y_r);
      tmcm_pkg::REG_PRESS_THR: prdata = DW'(press_thr_r);
      tmcm_pkg::REG_ORIENT:    prdata = DW'(orient_r);
      tmcm_pkg::REG_SCR_MAX_X: prdata = DW'(scr_max_x_r);
      tmcm_pkg::REG_SCR_MAX_Y: prdata = DW'(scr_max_y_r);
      default:                 prdata = '0;
    endcase
  end

  assign raw_min_x = raw_min_x_r;
  assign raw_max_x = raw_max_x_r;
  assign raw_min_y = raw_min_y_r;
  assign raw_max_y = raw_max_y_r;
  assign press_thr = press_thr_r;
  assign orient    = orient_r;
  assign scr_max_x = scr_max_x_r;
  assign scr_max_y = scr_max_y_r;

endmodule

/* hdl/tmcm_median.sv */
// ----------------------------------------------------------------------------
// tmcm_median: sample grouping and median of three
// Holds the first two samples of each group and forms the per-channel median
// when the third arrives.
// ----------------------------------------------------------------------------
module tmcm_median #(
  parameter int RAW_BITS = 12
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                fire,
  input  logic [RAW_BITS-1:0] sx,
  input  logic [RAW_BITS-1:0] sy,
  input  logic [RAW_BITS-1:0] sz,
  output logic                med_valid,
  output logic [RAW_BITS-1:0] mx,
  output logic [RAW_BITS-1:0] my,
  output logic [RAW_BITS-1:0] mz
);

  logic [1:0] phase_r, phase_nxt;
  logic       med_valid_r;
  logic [RAW_BITS-1:0] held_x_r [2];
  logic [RAW_BITS-1:0] held_y_r [2];
  logic [RAW_BITS-1:0] held_z_r [2];
  logic [RAW_BITS-1:0] mx_r, my_r, mz_r;
  logic                hold;

  function automatic logic [RAW_BITS-1:0] med3(
    input logic [RAW_BITS-1:0] a,
    input logic [RAW_BITS-1:0] b,
    input logic [RAW_BITS-1:0] c
  );
    logic [RAW_BITS-1:0] lo;
    logic [RAW_BITS-1:0] hi;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    if (c <= lo) med3 = lo;
    else if (c >= hi) med3 = hi;
    else med3 = c;
  endfunction

  assign hold = (phase_r < 2'd2);

  always_comb begin
    phase_nxt = phase_r;
    if (fire) phase_nxt = hold ? phase_r + 2'd1 : 2'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= 2'd0;
      med_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      med_valid_r <= fire & ~hold;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && hold) begin
      held_x_r[phase_r[0]] <= sx;
      held_y_r[phase_r[0]] <= sy;
      held_z_r[phase_r[0]] <= sz;
    end
    if (fire && !hold) begin
      mx_r <= med3(held_x_r[0], held_x_r[1], sx);
      my_r <= med3(held_y_r[0], held_y_r[1], sy);
      mz_r <= med3(held_z_r[0], held_z_r[1], sz);
    end
  end

  assign med_valid = med_valid_r;
  assign mx = mx_r;
  assign my = my_r;
  assign mz = mz_r;

endmodule

/* hdl/tmcm_muldiv.sv */
// ----------------------------------------------------------------------------
// tmcm_muldiv: bit-serial scale unit
// Multiplies the clamped offset by the screen maximum one multiplier bit per
// cycle, then divides by the raw span one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tmcm_muldiv #(
  parameter int RAW_BITS = 12
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [RAW_BITS-1:0]           num,
  input  logic [tmcm_pkg::SCR_BITS-1:0] smax,
  input  logic [RAW_BITS-1:0]           den,
  output logic                          done,
  output logic [tmcm_pkg::SCR_BITS-1:0] quo
);

  localparam int SB = tmcm_pkg::SCR_BITS;
  localparam int W  = RAW_BITS + SB;
  localparam int CW = $clog2(W);

  tmcm_pkg::md_state_t state_r, state_nxt;

  logic [CW-1:0]       cnt_r;
  logic [W-1:0]        pq_r;
  logic [W-1:0]        mcand_r;
  logic [SB-1:0]       mult_r;
  logic [RAW_BITS-1:0] den_r;
  logic [RAW_BITS-1:0] rem_r;
  logic [RAW_BITS:0]   trial;
  logic                ge;
  logic [RAW_BITS:0]   diff;

  assign trial = {rem_r, pq_r[W-1]};
  assign ge    = (trial >= {1'b0, den_r});
  assign diff  = trial - {1'b0, den_r};

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tmcm_pkg::MD_IDLE: if (start) state_nxt = tmcm_pkg::MD_MUL;
      tmcm_pkg::MD_MUL:  if (cnt_r == CW'(SB - 1)) state_nxt = tmcm_pkg::MD_DIV;
      tmcm_pkg::MD_DIV:  if (cnt_r == CW'(W - 1)) state_nxt = tmcm_pkg::MD_DONE;
      tmcm_pkg::MD_DONE: state_nxt = tmcm_pkg::MD_IDLE;
      default:           state_nxt = tmcm_pkg::MD_IDLE;
    endcase
  end

  always_comb begin
    case (state_r)
      tmcm_pkg::MD_DONE: done = 1'b1;
      default:           done = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= tmcm_pkg::MD_IDLE;
    else state_r <= state_nxt;
  end

  always_ff @(posedge clk) begin
    case (state_r)
      tmcm_pkg::MD_IDLE: begin
        cnt_r   <= '0;
        pq_r    <= '0;
        mcand_r <= W'(num);
        mult_r  <= smax;
        den_r   <= den;
        rem_r   <= '0;
      end
      tmcm_pkg::MD_MUL: begin
        if (mult_r[0]) pq_r <= pq_r + mcand_r;
        mcand_r <= {mcand_r[W-2:0], 1'b0};
        mult_r  <= {1'b0, mult_r[SB-1:1]};
        cnt_r   <= (cnt_r == CW'(SB - 1)) ? '0 : cnt_r + CW'(1);
      end
      tmcm_pkg::MD_DIV: begin
        rem_r <= ge ? diff[RAW_BITS-1:0] : trial[RAW_BITS-1:0];
        pq_r  <= {pq_r[W-2:0], ge};
        cnt_r <= cnt_r + CW'(1);
      end
      default: ;
    endcase
  end

  assign quo = pq_r[SB-1:0];

endmodule

/* hdl/touch_median_calibrate_map.sv */
// ----------------------------------------------------------------------------
// touch_median_calibrate_map: touch sample median filter and screen mapping
// Median of three per channel, pressure test, axis swap and mirror, clamp to
// calibration bounds and serial linear scaling to screen coordinates.
// ----------------------------------------------------------------------------
//  channel  direction  payload
//  in_*     slave      tdata: sample_x, sample_y, sample_z
//  out_*    master     tdata: screen_x, screen_y; tuser: touched
//  cfg_*    apb slave  eight registers at byte address 4*i
//
// The first two samples of a group are only held. The third starts a sequence
// from its accept cycle to the load of the output register, which runs the
// shared bit-serial multiply and divide unit once per axis; an untouched group
// or an empty axis skips the unit. Reset is synchronous; no clearing pass
// is needed. A result ready while the output register is still full holds
// the sequencer in its last state until taken; the input is held off until
// it is idle.
// ----------------------------------------------------------------------------
module touch_median_calibrate_map #(
  parameter int RAW_BITS = 12
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // sample_x, sample_y, sample_z, zero fill
  input  logic [((3*RAW_BITS+7)/8)*8-1:0]       in_tdata,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // screen_x, screen_y, zero fill
  output logic [23:0]                           out_tdata,
  // touched
  output logic                                  out_tuser,
  input  logic                                  cfg_psel,
  input  logic                                  cfg_penable,
  input  logic                                  cfg_pwrite,
  input  logic [tmcm_pkg::CFG_ADDR_BITS-1:0]    cfg_paddr,
  input  logic [tmcm_pkg::CFG_DATA_BITS-1:0]    cfg_pwdata,
  output logic [tmcm_pkg::CFG_DATA_BITS-1:0]    cfg_prdata,
  output logic                                  cfg_pready
);

  localparam int SB = tmcm_pkg::SCR_BITS;

  logic [RAW_BITS-1:0] raw_min_x, raw_max_x, raw_min_y, raw_max_y, press_thr;
  logic [3:0]          orient;
  logic [SB-1:0]       scr_max_x, scr_max_y;

  logic                in_fire;
  logic                med_valid;
  logic [RAW_BITS-1:0] mx, my, mz;

  tmcm_pkg::top_state_t state_r, state_nxt;

  logic                axis_r;
  logic                touched_r;
  logic [RAW_BITS:0]   v_r;
  logic [RAW_BITS-1:0] num_r, den_r;
  logic                empty_r;
  logic [SB-1:0]       res_x_r, res_y_r;
  logic                out_valid_r;
  logic [SB-1:0]       out_x_r, out_y_r;
  logic                out_touched_r;

  logic                md_start, md_done;
  logic [SB-1:0]       md_quo;
  logic                out_load;

  logic [RAW_BITS-1:0] ax_lo, ax_hi, ax_v, clamped;
  logic [SB-1:0]       ax_smax;
  logic                ax_mirror;
  logic [RAW_BITS:0]   sum;
  logic                z_touch;

  assign cfg_pready = 1'b1;

  tmcm_regs #(.RAW_BITS(RAW_BITS)) u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .psel      (cfg_psel),
    .penable   (cfg_penable),
    .pwrite    (cfg_pwrite),
    .paddr     (cfg_paddr),
    .pwdata    (cfg_pwdata),
    .prdata    (cfg_prdata),
    .raw_min_x (raw_min_x),
    .raw_max_x (raw_max_x),
    .raw_min_y (raw_min_y),
    .raw_max_y (raw_max_y),
    .press_thr (press_thr),
    .orient    (orient),
    .scr_max_x (scr_max_x),
    .scr_max_y (scr_max_y)
  );

  assign in_fire = in_tvalid & in_tready;

  tmcm_median #(.RAW_BITS(RAW_BITS)) u_median (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (in_fire),
    .sx        (in_tdata[RAW_BITS-1:0]),
    .sy        (in_tdata[2*RAW_BITS-1:RAW_BITS]),
    .sz        (in_tdata[3*RAW_BITS-1:2*RAW_BITS]),
    .med_valid (med_valid),
    .mx        (mx),
    .my        (my),
    .mz        (mz)
  );

  tmcm_muldiv #(.RAW_BITS(RAW_BITS)) u_muldiv (
    .clk   (clk),
    .rst_n (rst_n),
    .start (md_start),
    .num   (num_r),
    .smax  (ax_smax),
    .den   (den_r),
    .done  (md_done),
    .quo   (md_quo)
  );

  // per-axis operand selection
  always_comb begin
    if (!axis_r) begin
      ax_lo     = raw_min_x;
      ax_hi     = raw_max_x;
      ax_smax   = scr_max_x;
      ax_mirror = orient[tmcm_pkg::FLG_INV_X];
      ax_v      = orient[tmcm_pkg::FLG_SWAP] ? my : mx;
    end else begin
      ax_lo     = raw_min_y;
      ax_hi     = raw_max_y;
      ax_smax   = scr_max_y;
      ax_mirror = orient[tmcm_pkg::FLG_INV_Y];
      ax_v      = orient[tmcm_pkg::FLG_SWAP] ? mx : my;
    end
  end

  assign sum = {1'b0, ax_lo} + {1'b0, ax_hi};
  assign z_touch = orient[tmcm_pkg::FLG_LOW_Z] ? (mz <= press_thr) : (mz >= press_thr);

  always_comb begin
    if (v_r < {1'b0, ax_lo}) clamped = ax_lo;
    else if (v_r > {1'b0, ax_hi}) clamped = ax_hi;
    else clamped = v_r[RAW_BITS-1:0];
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tmcm_pkg::TS_IDLE:   if (med_valid) state_nxt = tmcm_pkg::TS_CHECK;
      tmcm_pkg::TS_CHECK:  state_nxt = z_touch ? tmcm_pkg::TS_MIRROR : tmcm_pkg::TS_OUT;
      tmcm_pkg::TS_MIRROR: state_nxt = tmcm_pkg::TS_CLAMP;
      tmcm_pkg::TS_CLAMP:  state_nxt = tmcm_pkg::TS_START;
      tmcm_pkg::TS_START: begin
        if (empty_r) state_nxt = axis_r ? tmcm_pkg::TS_OUT : tmcm_pkg::TS_MIRROR;
        else state_nxt = tmcm_pkg::TS_WAIT;
      end
      tmcm_pkg::TS_WAIT: begin
        if (md_done) state_nxt = axis_r ? tmcm_pkg::TS_OUT : tmcm_pkg::TS_MIRROR;
      end
      tmcm_pkg::TS_OUT: begin
        if (!out_valid_r || out_tready) state_nxt = tmcm_pkg::TS_IDLE;
      end
      default: state_nxt = tmcm_pkg::TS_IDLE;
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    md_start  = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      tmcm_pkg::TS_IDLE:  in_tready = 1'b1;
      tmcm_pkg::TS_START: md_start  = ~empty_r;
      tmcm_pkg::TS_OUT:   out_load  = ~out_valid_r | out_tready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= tmcm_pkg::TS_IDLE;
    else state_r <= state_nxt;
  end

  always_ff @(posedge clk) begin
    case (state_r)
      tmcm_pkg::TS_CHECK: begin
        touched_r <= z_touch;
        axis_r    <= 1'b0;
        res_x_r   <= '0;
        res_y_r   <= '0;
      end
      tmcm_pkg::TS_MIRROR: begin
        if (!ax_mirror) v_r <= {1'b0, ax_v};
        else if ({1'b0, ax_v} > sum) v_r <= {1'b0, ax_hi};
        else v_r <= sum - {1'b0, ax_v};
      end
      tmcm_pkg::TS_CLAMP: begin
        num_r   <= clamped - ax_lo;
        den_r   <= ax_hi - ax_lo;
        empty_r <= (ax_hi <= ax_lo);
      end
      tmcm_pkg::TS_START: begin
        if (empty_r) axis_r <= 1'b1;
      end
      tmcm_pkg::TS_WAIT: begin
        if (md_done) begin
          if (axis_r) res_y_r <= md_quo;
          else res_x_r <= md_quo;
          axis_r <= 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (out_load) out_valid_r <= 1'b1;
    else if (out_tready) out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_touched_r <= touched_r;
      out_x_r       <= res_x_r;
      out_y_r       <= res_y_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_touched_r;
  assign out_tdata  = {4'd0, out_y_r, out_x_r};

endmodule

/* tb/touch_median_calibrate_map_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// touch_median_calibrate_map_tb: self-checking bench for the touch mapper
// Streams raw touch samples in groups of three, predicts the median, the
// pressure decision and the calibrated screen point of every group, and
// compares each returned item field by field. Calibration is reprogrammed
// between phases over the register port, covering empty ranges, mirroring
// below zero and both pressure directions, under varying back-pressure.
// ----------------------------------------------------------------------------
module touch_median_calibrate_map_tb;

  localparam int RAW_BITS = 12;
  localparam int IN_W = ((3*RAW_BITS+7)/8)*8;
  localparam int RAW_TOP = (1 << RAW_BITS) - 1;
  localparam int SCR_TOP = (1 << tmcm_pkg::SCR_BITS) - 1;
  localparam int NUM_REGS = 8;
  localparam int RANDOM_PHASES = 6;
  localparam int GROUPS_PER_PHASE = 111;
  localparam int SETTLE_CYCLES = 100;
  localparam int STALL_AT = 600;
  localparam int STALL_CYCLES = 600;
  localparam int CYCLE_LIMIT = 1000000;

  typedef struct packed {
    logic [RAW_BITS-1:0] x;
    logic [RAW_BITS-1:0] y;
    logic [RAW_BITS-1:0] z;
  } sample_t;

  typedef struct packed {
    logic                          touched;
    logic [tmcm_pkg::SCR_BITS-1:0] sx;
    logic [tmcm_pkg::SCR_BITS-1:0] sy;
  } point_t;

  logic                               clk;
  logic                               rst_n = 1'b0;
  logic                               in_tvalid = 1'b0;
  logic                               in_tready;
  logic [IN_W-1:0]                    in_tdata = '0;
  logic                               out_tvalid;
  logic                               out_tready = 1'b0;
  logic [23:0]                        out_tdata;
  logic                               out_tuser;
  logic                               cfg_psel = 1'b0;
  logic                               cfg_penable = 1'b0;
  logic                               cfg_pwrite = 1'b0;
  logic [tmcm_pkg::CFG_ADDR_BITS-1:0] cfg_paddr = '0;
  logic [tmcm_pkg::CFG_DATA_BITS-1:0] cfg_pwdata = '0;
  logic [tmcm_pkg::CFG_DATA_BITS-1:0] cfg_prdata;
  logic                               cfg_pready;

  touch_median_calibrate_map #(.RAW_BITS(RAW_BITS)) dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  sample_t     sample_queue[$];
  point_t      expected_points[$];
  sample_t     on_bus;
  sample_t     held [2];
  int          group_fill = 0;
  int unsigned cal [NUM_REGS];
  int unsigned next_cal [NUM_REGS];
  int          tx_idle_pct = 0;
  int          rx_idle_pct = 0;
  int          items_queued = 0;
  int          items_accepted = 0;
  int          results_seen = 0;
  int          mismatch_count = 0;
  int          settings_used = 1;
  int          stall_left = 0;
  bit          stall_done = 1'b0;
  int          cycle_count = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic [RAW_BITS-1:0] mid_of_three(input logic [RAW_BITS-1:0] a, b, c);
    logic [RAW_BITS-1:0] lo;
    logic [RAW_BITS-1:0] hi;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    if (c <= lo) return lo;
    if (c >= hi) return hi;
    return c;
  endfunction

  function automatic logic [tmcm_pkg::SCR_BITS-1:0] scale_axis(input int unsigned v, lo, hi,
                                                               input bit mirror,
                                                               input int unsigned smax);
    int unsigned pos;
    int unsigned q;
    pos = v;
    if (mirror) pos = (v > lo + hi) ? hi : lo + hi - v;
    if (hi <= lo) return '0;
    if (pos < lo) pos = lo;
    if (pos > hi) pos = hi;
    q = (pos - lo) * smax / (hi - lo);
    return q[tmcm_pkg::SCR_BITS-1:0];
  endfunction

  // hold the first two samples of a group, resolve the third into a point
  function automatic void track_sample(input sample_t s);
    sample_t             m;
    point_t              p;
    logic [3:0]          flg;
    logic [RAW_BITS-1:0] ax;
    logic [RAW_BITS-1:0] ay;
    if (group_fill < 2) begin
      held[group_fill] = s;
      group_fill++;
    end else begin
      group_fill = 0;
      m.x = mid_of_three(held[0].x, held[1].x, s.x);
      m.y = mid_of_three(held[0].y, held[1].y, s.y);
      m.z = mid_of_three(held[0].z, held[1].z, s.z);
      flg = cal[tmcm_pkg::REG_ORIENT][3:0];
      p.touched = flg[tmcm_pkg::FLG_LOW_Z] ? (m.z <= cal[tmcm_pkg::REG_PRESS_THR])
                                           : (m.z >= cal[tmcm_pkg::REG_PRESS_THR]);
      p.sx = '0;
      p.sy = '0;
      if (p.touched) begin
        ax = flg[tmcm_pkg::FLG_SWAP] ? m.y : m.x;
        ay = flg[tmcm_pkg::FLG_SWAP] ? m.x : m.y;
        p.sx = scale_axis(ax, cal[tmcm_pkg::REG_RAW_MIN_X], cal[tmcm_pkg::REG_RAW_MAX_X],
                          flg[tmcm_pkg::FLG_INV_X], cal[tmcm_pkg::REG_SCR_MAX_X]);
        p.sy = scale_axis(ay, cal[tmcm_pkg::REG_RAW_MIN_Y], cal[tmcm_pkg::REG_RAW_MAX_Y],
                          flg[tmcm_pkg::FLG_INV_Y], cal[tmcm_pkg::REG_SCR_MAX_Y]);
      end
      expected_points.push_back(p);
    end
  endfunction

  function automatic int clip_raw(input int v);
    if (v < 0) return 0;
    if (v > RAW_TOP) return RAW_TOP;
    return v;
  endfunction

  function automatic void push_sample(input int x, y, z);
    sample_t s;
    s.x = RAW_BITS'(clip_raw(x));
    s.y = RAW_BITS'(clip_raw(y));
    s.z = RAW_BITS'(clip_raw(z));
    sample_queue.push_back(s);
    items_queued++;
  endfunction

  function automatic void push_triple(input int x, y, z);
    repeat (3) push_sample(x, y, z);
  endfunction

  // mostly a steady touch with jitter and at most one spike, else pure noise
  function automatic void push_random_group();
    int cx, cy, cz, spread, odd;
    cx = $urandom_range(0, RAW_TOP);
    cy = $urandom_range(0, RAW_TOP);
    if ($urandom_range(0, 1))
      cz = int'(cal[tmcm_pkg::REG_PRESS_THR]) + int'($urandom_range(0, 64)) - 32;
    else cz = $urandom_range(0, RAW_TOP);
    spread = $urandom_range(0, 40);
    odd = $urandom_range(0, 3);
    if ($urandom_range(0, 9) < 3) begin
      repeat (3) push_sample($urandom_range(0, RAW_TOP), $urandom_range(0, RAW_TOP),
                             $urandom_range(0, RAW_TOP));
    end else begin
      for (int k = 0; k < 3; k++) begin
        if (k == odd)
          push_sample($urandom_range(0, RAW_TOP), $urandom_range(0, RAW_TOP),
                      $urandom_range(0, RAW_TOP));
        else
          push_sample(cx + int'($urandom_range(0, 2*spread)) - spread,
                      cy + int'($urandom_range(0, 2*spread)) - spread,
                      cz + int'($urandom_range(0, 2*spread)) - spread);
      end
    end
  endfunction

  function automatic void pick_cal_range(output int unsigned lo, hi);
    case ($urandom_range(0, 5))
      0: begin
        lo = 0;
        hi = RAW_TOP;
      end
      1: begin
        hi = $urandom_range(0, RAW_TOP);
        lo = $urandom_range(hi, RAW_TOP);
      end
      2: begin
        lo = $urandom_range(0, 300);
        hi = $urandom_range(lo + 1, 1500);
      end
      default: begin
        lo = $urandom_range(0, 2047);
        hi = $urandom_range(lo + 1, RAW_TOP);
      end
    endcase
  endfunction

  function automatic int unsigned pick_screen_max();
    case ($urandom_range(0, 4))
      0: return 0;
      1: return SCR_TOP;
      default: return $urandom_range(0, SCR_TOP);
    endcase
  endfunction

  task automatic write_cal(input logic [tmcm_pkg::REG_IDX_BITS-1:0] idx,
                           input int unsigned val);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cal[idx] = val;
  endtask

  task automatic program_cal();
    for (int i = 0; i < NUM_REGS; i++) write_cal(i[tmcm_pkg::REG_IDX_BITS-1:0], next_cal[i]);
    settings_used++;
  endtask

  // hold until every sample is taken and every point is back, then settle
  task automatic drain();
    while (items_accepted != items_queued || expected_points.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        track_sample(on_bus);
        items_accepted++;
      end
      if (!in_tvalid || in_tready) begin
        if (sample_queue.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
          on_bus = sample_queue.pop_front();
          in_tdata  <= IN_W'({on_bus.z, on_bus.y, on_bus.x});
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    point_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        results_seen++;
        if (expected_points.size() == 0) begin
          $error("unexpected item: touched %0b screen_x %0d screen_y %0d",
                 out_tuser, out_tdata[9:0], out_tdata[19:10]);
          mismatch_count++;
        end else begin
          want = expected_points.pop_front();
          if (out_tuser !== want.touched) begin
            $error("touched: expected %0b, got %0b", want.touched, out_tuser);
            mismatch_count++;
          end
          if (out_tdata[9:0] !== want.sx) begin
            $error("screen_x: expected %0d, got %0d", want.sx, out_tdata[9:0]);
            mismatch_count++;
          end
          if (out_tdata[19:10] !== want.sy) begin
            $error("screen_y: expected %0d, got %0d", want.sy, out_tdata[19:10]);
            mismatch_count++;
          end
        end
      end
      if (!stall_done && results_seen == STALL_AT) begin
        stall_left = STALL_CYCLES;
        stall_done = 1'b1;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("touch_median_calibrate_map_tb: FAIL");
      $finish;
    end
  end

  initial begin
    cal[tmcm_pkg::REG_RAW_MIN_X] = tmcm_pkg::RST_RAW_MIN;
    cal[tmcm_pkg::REG_RAW_MAX_X] = tmcm_pkg::RST_RAW_MAX;
    cal[tmcm_pkg::REG_RAW_MIN_Y] = tmcm_pkg::RST_RAW_MIN;
    cal[tmcm_pkg::REG_RAW_MAX_Y] = tmcm_pkg::RST_RAW_MAX;
    cal[tmcm_pkg::REG_PRESS_THR] = tmcm_pkg::RST_PRESS_THR;
    cal[tmcm_pkg::REG_ORIENT]    = tmcm_pkg::RST_ORIENT;
    cal[tmcm_pkg::REG_SCR_MAX_X] = tmcm_pkg::RST_SCR_MAX_X;
    cal[tmcm_pkg::REG_SCR_MAX_Y] = tmcm_pkg::RST_SCR_MAX_Y;
    tx_idle_pct = 20;
    rx_idle_pct = 80;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // reset calibration: swapped, y mirrored, low pressure means touch
    push_sample(0, 0, 0);
    push_sample(RAW_TOP, RAW_TOP, RAW_TOP);
    push_sample(2000, 3000, 100);
    push_triple(RAW_TOP, RAW_TOP, RAW_TOP);
    push_sample(3000, 100, 850);
    push_sample(1000, 4000, 900);
    push_sample(0, RAW_TOP, 0);
    push_sample(550, 3650, 800);
    push_sample(3650, 550, 860);
    push_sample(2100, 2100, 851);
    drain();

    // x mirrored below zero, y range empty, only full pressure touches
    next_cal[tmcm_pkg::REG_RAW_MIN_X] = 100;
    next_cal[tmcm_pkg::REG_RAW_MAX_X] = 1000;
    next_cal[tmcm_pkg::REG_RAW_MIN_Y] = RAW_TOP;
    next_cal[tmcm_pkg::REG_RAW_MAX_Y] = 0;
    next_cal[tmcm_pkg::REG_PRESS_THR] = RAW_TOP;
    next_cal[tmcm_pkg::REG_ORIENT]    = 1 << tmcm_pkg::FLG_INV_X;
    next_cal[tmcm_pkg::REG_SCR_MAX_X] = SCR_TOP;
    next_cal[tmcm_pkg::REG_SCR_MAX_Y] = 0;
    program_cal();
    push_triple(RAW_TOP, 5, RAW_TOP);
    push_triple(0, 2000, RAW_TOP - 1);
    push_triple(550, RAW_TOP, RAW_TOP);
    drain();

    // all flags set, full ranges, only zero pressure touches
    next_cal[tmcm_pkg::REG_RAW_MIN_X] = 0;
    next_cal[tmcm_pkg::REG_RAW_MAX_X] = RAW_TOP;
    next_cal[tmcm_pkg::REG_RAW_MIN_Y] = 0;
    next_cal[tmcm_pkg::REG_RAW_MAX_Y] = RAW_TOP;
    next_cal[tmcm_pkg::REG_PRESS_THR] = 0;
    next_cal[tmcm_pkg::REG_ORIENT]    = 15;
    next_cal[tmcm_pkg::REG_SCR_MAX_X] = SCR_TOP;
    next_cal[tmcm_pkg::REG_SCR_MAX_Y] = SCR_TOP;
    program_cal();
    push_triple(0, RAW_TOP, 0);
    drain();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      if (p == 2) begin
        tx_idle_pct = 80;
        rx_idle_pct = 20;
      end
      if (p == 4) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      pick_cal_range(next_cal[tmcm_pkg::REG_RAW_MIN_X], next_cal[tmcm_pkg::REG_RAW_MAX_X]);
      pick_cal_range(next_cal[tmcm_pkg::REG_RAW_MIN_Y], next_cal[tmcm_pkg::REG_RAW_MAX_Y]);
      case ($urandom_range(0, 4))
        0: next_cal[tmcm_pkg::REG_PRESS_THR] = 0;
        1: next_cal[tmcm_pkg::REG_PRESS_THR] = RAW_TOP;
        default: next_cal[tmcm_pkg::REG_PRESS_THR] = $urandom_range(200, 3800);
      endcase
      next_cal[tmcm_pkg::REG_ORIENT]    = $urandom_range(0, 15);
      next_cal[tmcm_pkg::REG_SCR_MAX_X] = pick_screen_max();
      next_cal[tmcm_pkg::REG_SCR_MAX_Y] = pick_screen_max();
      program_cal();
      repeat (GROUPS_PER_PHASE) push_random_group();
      drain();
    end

    $display("%0d samples sent, %0d points checked across %0d calibration settings",
             items_accepted, results_seen, settings_used);
    $display("idle patterns on both sides plus one %0d-cycle output hold-off",
             STALL_CYCLES);
    if (mismatch_count == 0) begin
      $display("touch_median_calibrate_map_tb: PASS");
    end else begin
      $display("touch_median_calibrate_map_tb: FAIL");
    end
    $finish;
  end

endmodule
